// ----- sv/uvs_pkg.sv -----
`timescale 1ns / 1ps
package uvs_pkg;
    localparam int MaxPoints    = 256;
    localparam int CordicStages = 16;
    localparam int CntW         = 9;
    localparam int PhW          = 32;
    localparam int AngW         = 34;
    localparam int DivSteps     = 41;
    localparam logic [AngW-1:0] CordicGain = 34'h026DD3B6A;

    localparam logic [1:0] RegLong   = 2'd0;
    localparam logic [1:0] RegLat    = 2'd1;
    localparam logic [1:0] RegRadius = 2'd2;

    typedef struct packed {
        logic [7:0]  i;
        logic [7:0]  j;
        logic        err;
        logic [8:0]  l_cnt;
        logic [8:0]  r_cnt;
        logic [15:0] radius;
    } ctl_t;

    typedef struct packed {
        logic [40:0] lat_rem;
        logic [40:0] lat_quo;
        logic [40:0] long_rem;
        logic [40:0] long_quo;
    } div_t;

    typedef struct packed {
        logic signed [AngW-1:0] x;
        logic signed [AngW-1:0] y;
        logic signed [AngW-1:0] z;
        logic                   flip;
    } rot_t;

    function automatic logic signed [AngW-1:0] atan_turn(input int k);
        case (k)
            0:  atan_turn = 34'sh020000000;
            1:  atan_turn = 34'sh012E4051D;
            2:  atan_turn = 34'sh009FB385B;
            3:  atan_turn = 34'sh0051111D4;
            4:  atan_turn = 34'sh0028B0D43;
            5:  atan_turn = 34'sh00145D7E1;
            6:  atan_turn = 34'sh000A2F61E;
            7:  atan_turn = 34'sh000517C55;
            8:  atan_turn = 34'sh00028BE53;
            9:  atan_turn = 34'sh000145F2E;
            10: atan_turn = 34'sh0000A2F98;
            11: atan_turn = 34'sh0000517CC;
            12: atan_turn = 34'sh000028BE6;
            13: atan_turn = 34'sh0000145F3;
            14: atan_turn = 34'sh00000A2F9;
            15: atan_turn = 34'sh00000517C;
            16: atan_turn = 34'sh0000028BE;
            17: atan_turn = 34'sh00000145F;
            18: atan_turn = 34'sh000000A2F;
            19: atan_turn = 34'sh000000517;
            20: atan_turn = 34'sh00000028B;
            21: atan_turn = 34'sh000000145;
            22: atan_turn = 34'sh0000000A2;
            23: atan_turn = 34'sh000000051;
            default: atan_turn = '0;
        endcase
    endfunction
endpackage

// ----- sv/uvs_div_cell.sv -----
`timescale 1ns / 1ps
module uvs_div_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         v_in,
    input  uvs_pkg::ctl_t c_in,
    input  uvs_pkg::div_t d_in,
    output logic         v_out,
    output uvs_pkg::ctl_t c_out,
    output uvs_pkg::div_t d_out
);
    import uvs_pkg::*;
    logic  v_reg;
    ctl_t  c_reg;
    div_t  d_reg, d_next;
    logic [41:0] lt, gt;

    always_comb
    begin
        d_next = d_in;
        lt = {d_in.lat_rem, d_in.lat_quo[40]};
        if (lt >= {33'd0, c_in.r_cnt})
        begin
            lt = lt - {33'd0, c_in.r_cnt};
            d_next.lat_quo = {d_in.lat_quo[39:0], 1'b1};
        end
        else
        begin
            d_next.lat_quo = {d_in.lat_quo[39:0], 1'b0};
        end
        d_next.lat_rem = lt[40:0];
        gt = {d_in.long_rem, d_in.long_quo[40]};
        if (gt >= {33'd0, c_in.l_cnt})
        begin
            gt = gt - {33'd0, c_in.l_cnt};
            d_next.long_quo = {d_in.long_quo[39:0], 1'b1};
        end
        else
        begin
            d_next.long_quo = {d_in.long_quo[39:0], 1'b0};
        end
        d_next.long_rem = gt[40:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_in;
        d_reg <= d_next;
    end

    assign v_out = v_reg;
    assign c_out = c_reg;
    assign d_out = d_reg;
endmodule

// ----- sv/uvs_cordic_cell.sv -----
`timescale 1ns / 1ps
module uvs_cordic_cell (
    input  logic          clk,
    input  logic [4:0]    stage,
    input  uvs_pkg::rot_t lat_in,
    input  uvs_pkg::rot_t long_in,
    output uvs_pkg::rot_t lat_out,
    output uvs_pkg::rot_t long_out
);
    import uvs_pkg::*;
    rot_t a_reg, b_reg;

    function automatic rot_t step(input rot_t r, input logic [4:0] k);
        rot_t o;
        o = r;
        if (!r.z[AngW-1])
        begin
            o.x = r.x - (r.y >>> k);
            o.y = r.y + (r.x >>> k);
            o.z = r.z - atan_turn(int'(k));
        end
        else
        begin
            o.x = r.x + (r.y >>> k);
            o.y = r.y - (r.x >>> k);
            o.z = r.z + atan_turn(int'(k));
        end
        return o;
    endfunction

    always_ff @(posedge clk)
    begin
        a_reg <= step(lat_in, stage);
        b_reg <= step(long_in, stage);
    end

    assign lat_out  = a_reg;
    assign long_out = b_reg;
endmodule

// ----- sv/uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
// Pipeline: 41 divider cells, 1 fold stage, 16 CORDIC cells and 4 output stages.
// One point is accepted per cycle; busy is held low, start is taken every cycle.
// Results appear with done for one cycle; the receiver cannot stall.
// Reset (rst_n low, async) clears the pipeline valids and loads
// long_points = 16, lat_points = 16, radius = 1.0.
module uv_sphere_vertex_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         lat_index,
    input  logic [7:0]         long_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic [15:0]        corner_a,
    output logic [15:0]        corner_b,
    output logic [15:0]        corner_c,
    output logic [15:0]        corner_d,
    output logic               index_error
);
    import uvs_pkg::*;

    logic [8:0]  long_reg, lat_reg;
    logic [15:0] radius_reg;
    logic [8:0]  l_eff, r_eff;
    logic        acc;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign acc       = start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg   <= 9'd16;
            lat_reg    <= 9'd16;
            radius_reg <= 16'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegLong:   long_reg   <= cfg_data[8:0];
                RegLat:    lat_reg    <= cfg_data[8:0];
                RegRadius: radius_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign l_eff = (long_reg > 9'(MaxPoints)) ? 9'(MaxPoints) : long_reg;
    assign r_eff = (lat_reg > 9'(MaxPoints)) ? 9'(MaxPoints) : lat_reg;

    // divider chain
    logic v_d [0:DivSteps];
    ctl_t c_d [0:DivSteps];
    div_t d_d [0:DivSteps];

    always_comb
    begin
        c_d[0].i      = lat_index;
        c_d[0].j      = long_index;
        c_d[0].err    = ({1'b0, lat_index} >= r_eff) || ({1'b0, long_index} >= l_eff);
        c_d[0].l_cnt  = l_eff;
        c_d[0].r_cnt  = r_eff;
        c_d[0].radius = radius_reg;
        v_d[0]        = acc;
        d_d[0].lat_rem  = '0;
        d_d[0].lat_quo  = {1'b0, lat_index, 32'd0} >> 1;
        d_d[0].long_rem = '0;
        d_d[0].long_quo = {1'b0, long_index, 32'd0};
    end

    for (genvar g = 0; g < DivSteps; g++)
    begin : g_div
        uvs_div_cell u_cell (
            .clk(clk), .rst_n(rst_n),
            .v_in(v_d[g]), .c_in(c_d[g]), .d_in(d_d[g]),
            .v_out(v_d[g+1]), .c_out(c_d[g+1]), .d_out(d_d[g+1])
        );
    end

    // fold stage
    logic [31:0] lat_ph, long_ph;
    assign lat_ph  = d_d[DivSteps].lat_quo[31:0] - 32'h40000000;
    assign long_ph = d_d[DivSteps].long_quo[31:0];

    function automatic rot_t fold(input logic [31:0] ph);
        rot_t r;
        logic [31:0] p;
        r.flip = ph[31] ^ ph[30];
        p = r.flip ? ph + 32'h80000000 : ph;
        r.x = $signed(CordicGain);
        r.y = '0;
        r.z = {{2{p[31]}}, p};
        return r;
    endfunction

    localparam int CL = DivSteps + 1 + CordicStages + 4;
    logic v_p [DivSteps+1:CL];
    ctl_t c_p [DivSteps+1:CL];
    rot_t la [0:CordicStages];
    rot_t lo [0:CordicStages];
    rot_t la_f_reg, lo_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = DivSteps+1; k <= CL; k++) v_p[k] <= 1'b0;
        end
        else
        begin
            v_p[DivSteps+1] <= v_d[DivSteps];
            for (int k = DivSteps+2; k <= CL; k++) v_p[k] <= v_p[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c_p[DivSteps+1] <= c_d[DivSteps];
        for (int k = DivSteps+2; k <= CL; k++) c_p[k] <= c_p[k-1];
        la_f_reg <= fold(lat_ph);
        lo_f_reg <= fold(long_ph);
    end

    assign la[0] = la_f_reg;
    assign lo[0] = lo_f_reg;

    for (genvar g = 0; g < CordicStages; g++)
    begin : g_cor
        uvs_cordic_cell u_cell (
            .clk(clk), .stage(5'(g)), .lat_in(la[g]), .long_in(lo[g]),
            .lat_out(la[g+1]), .long_out(lo[g+1])
        );
    end

    // unflip, multiply
    logic signed [AngW-1:0] clat, slat, clong, slong;
    assign clat  = la[CordicStages].flip ? -la[CordicStages].x : la[CordicStages].x;
    assign slat  = la[CordicStages].flip ? -la[CordicStages].y : la[CordicStages].y;
    assign clong = lo[CordicStages].flip ? -lo[CordicStages].x : lo[CordicStages].x;
    assign slong = lo[CordicStages].flip ? -lo[CordicStages].y : lo[CordicStages].y;

    logic signed [AngW-1:0] clat_reg, slat_reg, clong_reg, slong_reg;
    logic signed [67:0] px_reg, pz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [16:0] sy_reg;

    function automatic logic signed [15:0] sat16(input logic signed [67:0] v, input int k);
        logic signed [67:0] r;
        r = (v + (68'sd1 <<< (k-1))) >>> k;
        if (r > 68'sd32767) return 16'sh7FFF;
        if (r < -68'sd32768) return 16'sh8000;
        return r[15:0];
    endfunction

    function automatic logic signed [16:0] scale(input logic [15:0] r, input logic signed [15:0] n);
        logic signed [33:0] p;
        p = $signed({1'b0, r}) * n + 34'sd16384;
        return p[31:15];
    endfunction

    logic [15:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [7:0]  i1, j1;
    ctl_t cm;
    assign cm = c_p[DivSteps+2+CordicStages];
    assign i1 = ({1'b0, cm.i} + 9'd1 == cm.r_cnt) ? 8'd0 : cm.i + 8'd1;
    assign j1 = ({1'b0, cm.j} + 9'd1 == cm.l_cnt) ? 8'd0 : cm.j + 8'd1;
    logic [15:0] ri_reg, ri1_reg, ci_reg, cj1_reg;
    logic [15:0] ca2_reg, cb2_reg, cc2_reg, cd2_reg;
    logic signed [16:0] px2_reg, py2_reg, pz2_reg;
    logic signed [15:0] nx2_reg, ny2_reg, nz2_reg;

    always_ff @(posedge clk)
    begin
        clat_reg  <= clat;
        slat_reg  <= slat;
        clong_reg <= clong;
        slong_reg <= slong;
        ri_reg    <= 16'(cm.i * cm.l_cnt);
        ri1_reg   <= 16'(i1 * cm.l_cnt);
        ci_reg    <= {8'd0, cm.j};
        cj1_reg   <= {8'd0, j1};
        px_reg    <= clong_reg * clat_reg;
        pz_reg    <= slong_reg * clat_reg;
        sy_reg    <= 17'(sat16({{34{slat_reg[AngW-1]}}, slat_reg}, 15));
        ca_reg    <= ri_reg + ci_reg;
        cb_reg    <= ri1_reg + ci_reg;
        cc_reg    <= ri1_reg + cj1_reg;
        cd_reg    <= ri_reg + cj1_reg;
        nx_reg    <= sat16(px_reg, 45);
        nz_reg    <= sat16(pz_reg, 45);
        ny_reg    <= sy_reg[15:0];
        ca2_reg   <= ca_reg;
        cb2_reg   <= cb_reg;
        cc2_reg   <= cc_reg;
        cd2_reg   <= cd_reg;
        px2_reg   <= scale(c_p[CL-1].radius, nx_reg);
        py2_reg   <= scale(c_p[CL-1].radius, ny_reg);
        pz2_reg   <= scale(c_p[CL-1].radius, nz_reg);
        nx2_reg   <= nx_reg;
        ny2_reg   <= ny_reg;
        nz2_reg   <= nz_reg;
    end

    logic e;
    assign e = c_p[CL].err;
    assign done        = v_p[CL];
    assign index_error = e;
    assign normal_x    = e ? '0 : nx2_reg;
    assign normal_y    = e ? '0 : ny2_reg;
    assign normal_z    = e ? '0 : nz2_reg;
    assign pos_x       = e ? '0 : px2_reg;
    assign pos_y       = e ? '0 : py2_reg;
    assign pos_z       = e ? '0 : pz2_reg;
    assign corner_a    = e ? '0 : ca2_reg;
    assign corner_b    = e ? '0 : cb2_reg;
    assign corner_c    = e ? '0 : cc2_reg;
    assign corner_d    = e ? '0 : cd2_reg;
endmodule

// ----- test/tb_uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
module tb_uv_sphere_vertex_generator;
    import uvs_pkg::*;

    localparam int Latency = 62;
    localparam int WatchLimit = 2000;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic signed [16:0] px, py, pz;
        logic [15:0] ca, cb, cc, cd;
        logic err;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [7:0] lat_index = '0;
    logic [7:0] long_index = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic done;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic [15:0] corner_a, corner_b, corner_c, corner_d;
    logic index_error;

    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;

    uv_sphere_vertex_generator dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint floor_shr(input longint v, input int k);
        return v >>> k;
    endfunction

    function automatic longint round_clip16(input longint v, input int k);
        longint r;
        r = floor_shr(v + (longint'(1) << (k - 1)), k);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic longint atan_step(input int k);
        longint tbl[16] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
            64'h00145F2E, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
            64'h0000A2F9, 64'h0000517C};
        return tbl[k];
    endfunction

    task automatic rotate_turn(input logic [31:0] phase, output longint c, output longint s);
        logic flip;
        logic [31:0] p;
        longint x, y, z, dx, dy;
        flip = ((phase + 32'h40000000) & 32'h80000000) != 0;
        p = flip ? phase + 32'h80000000 : phase;
        z = longint'($signed(p));
        x = 64'h26DD3B6A;
        y = 0;
        for (int k = 0; k < CordicStages; k++)
        begin
            dx = floor_shr(y, k);
            dy = floor_shr(x, k);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(k);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(k);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    class vertex_scoreboard;
        logic [8:0] long_cnt = 16, lat_cnt = 16;
        logic [15:0] rad = 256;
        vertex_t pending[$];

        function logic [16:0] scale(input longint n);
            return 17'(floor_shr(longint'(rad) * n + 16384, 15));
        endfunction

        task note_point(input logic [7:0] i, input logic [7:0] j);
            vertex_t v;
            int nl, nr, i1, j1;
            longint cl, sl, cg, sg, nx, ny, nz;
            logic [31:0] lp, gp;
            v = '{default: '0};
            nl = long_cnt > MaxPoints ? MaxPoints : long_cnt;
            nr = lat_cnt > MaxPoints ? MaxPoints : lat_cnt;
            if (i >= nr || j >= nl)
                v.err = 1'b1;
            else
            begin
                lp = 32'((longint'(i) << 31) / nr) - 32'h40000000;
                gp = 32'((longint'(j) << 32) / nl);
                rotate_turn(lp, cl, sl);
                rotate_turn(gp, cg, sg);
                nx = round_clip16(cg * cl, 45);
                ny = round_clip16(sl, 15);
                nz = round_clip16(sg * cl, 45);
                v.nx = 16'(nx); v.ny = 16'(ny); v.nz = 16'(nz);
                v.px = scale(nx); v.py = scale(ny); v.pz = scale(nz);
                i1 = (i + 1 == nr) ? 0 : i + 1;
                j1 = (j + 1 == nl) ? 0 : j + 1;
                v.ca = 16'(i * nl + j);
                v.cb = 16'(i1 * nl + j);
                v.cc = 16'(i1 * nl + j1);
                v.cd = 16'(i * nl + j1);
            end
            pending.push_back(v);
        endtask

        task check_vertex(input vertex_t got);
            vertex_t w;
            if (pending.size() == 0)
            begin
                report("unexpected beat", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.nx !== w.nx) report("normal_x", got.nx, w.nx);
            if (got.ny !== w.ny) report("normal_y", got.ny, w.ny);
            if (got.nz !== w.nz) report("normal_z", got.nz, w.nz);
            if (got.px !== w.px) report("pos_x", got.px, w.px);
            if (got.py !== w.py) report("pos_y", got.py, w.py);
            if (got.pz !== w.pz) report("pos_z", got.pz, w.pz);
            if (got.ca !== w.ca) report("corner_a", got.ca, w.ca);
            if (got.cb !== w.cb) report("corner_b", got.cb, w.cb);
            if (got.cc !== w.cc) report("corner_c", got.cc, w.cc);
            if (got.cd !== w.cd) report("corner_d", got.cd, w.cd);
            if (got.err !== w.err) report("index_error", got.err, w.err);
        endtask
    endclass

    vertex_scoreboard board = new();

    always @(posedge clk)
    begin
        vertex_t got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                board.note_point(lat_index, long_index);
            end
            if (done)
            begin
                got.nx = normal_x; got.ny = normal_y; got.nz = normal_z;
                got.px = pos_x; got.py = pos_y; got.pz = pos_z;
                got.ca = corner_a; got.cb = corner_b; got.cc = corner_c;
                got.cd = corner_d; got.err = index_error;
                board.check_vertex(got);
            end
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_point(input logic [7:0] i, input logic [7:0] j);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        lat_index <= i;
        long_index <= j;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (Latency + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == RegLong) board.long_cnt = val[8:0];
        else if (idx == RegLat) board.lat_cnt = val[8:0];
        else if (idx == RegRadius) board.rad = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input int nl, input int nr, input int rad);
        drain();
        write_reg(RegLong, 16'(nl));
        write_reg(RegLat, 16'(nr));
        write_reg(RegRadius, 16'(rad));
    endtask

    task automatic random_points(input int n);
        int nl, nr;
        nl = board.long_cnt > MaxPoints ? MaxPoints : board.long_cnt;
        nr = board.lat_cnt > MaxPoints ? MaxPoints : board.lat_cnt;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) == 0 || nl == 0 || nr == 0)
                send_point(8'($urandom), 8'($urandom));
            else
                send_point(8'($urandom_range(nr - 1)), 8'($urandom_range(nl - 1)));
        end
    endtask

    initial
    begin
        int pcts[4] = '{0, 46, 0, 31};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_point(8'd0, 8'd0);
        send_point(8'd8, 8'd0);
        send_point(8'd15, 8'd15);
        send_point(8'd4, 8'd4);
        send_point(8'd16, 8'd0);
        send_point(8'd0, 8'd16);
        send_point(8'd255, 8'd255);
        send_point(8'd8, 8'd12);
        set_grid(256, 256, 16'hFFFF);
        send_point(8'd255, 8'd255);
        send_point(8'd0, 8'd0);
        send_point(8'd128, 8'd64);
        send_point(8'd64, 8'd192);
        set_grid(511, 300, 0);
        send_point(8'd255, 8'd255);
        send_point(8'd170, 8'd85);
        set_grid(1, 1, 16'h8000);
        send_point(8'd0, 8'd0);
        send_point(8'd1, 8'd0);
        set_grid(0, 5, 256);
        send_point(8'd0, 8'd0);
        send_point(8'd3, 8'd7);
        set_grid(2, 3, 16'h0001);
        send_point(8'd1, 8'd1);
        send_point(8'd2, 8'd0);
        drain();
        write_reg(2'd3, 16'hFFFF);

        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = pcts[ph % 4];
            set_grid($urandom_range(1, 300), $urandom_range(1, 300), $urandom);
            random_points(200);
        end
        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
